// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

// ===== sv/tmte_pkg.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal engine package
// Operation and control codes, command and result words, engine states.
// ----------------------------------------------------------------------------
package tmte_pkg;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	localparam logic [7:0] CHAR_BS    = 8'h08;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_LF    = 8'h0a;
	localparam logic [7:0] CHAR_CR    = 8'h0d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'h07;

	typedef enum logic [2:0] {
		CMD_PRINT,
		CMD_BS,
		CMD_TAB,
		CMD_LF,
		CMD_CR,
		CMD_READ,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  character;
		logic [10:0] cell_index;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPW = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic        scrolled;
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_row;
		logic [15:0] cell_value;
	} res_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_WRITE,
		ST_BLANK,
		ST_RDWAIT,
		ST_FILL,
		ST_RESP
	} back_state_t;

endpackage

// ===== sv/text_mode_terminal_engine.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal engine
// Takes character words and keeps a cursor and a ROWS x COLUMNS screen of
// 16-bit cells (attribute in the high byte, character in the low byte). Every
// input word gives exactly one result word carrying the cursor after the word,
// a scroll flag and, for a read, the cell. A word that scrolls also blanks the
// new bottom row, and a clear fills every cell; both go through the single
// write port of the screen memory, which is swept one cell per cycle. Scrolling
// does not move any cell: a base pointer rotates the rows, so only one row is
// written. After reset the engine fills the screen with spaces in attribute
// 0x07; input words are queued meanwhile and the color register can still be
// written. The front end decodes words into a two-entry queue, so it keeps
// accepting while the queue has room, even when the back end is busy or the
// result register is stalled.
// ----------------------------------------------------------------------------
module text_mode_terminal_engine #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// character [7:0], cell_index [18:8], zero [23:19]
	input  logic [23:0] s_tdata,
	// operation [1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_value [15:0], cursor_row [20:16], cursor_column [27:21],
	// scrolled [28], zero [31:29]
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	`include "assert_macros.svh"

	// The color register; the user must write it only while the engine is idle, which the block itself does not enforce.
	logic [7:0] text_color_q;

	tmte_pkg::q_stat_t q_stat;
	tmte_pkg::cmd_t    push_cmd;
	tmte_pkg::cmd_t    head_cmd;
	tmte_pkg::res_t    res;
	logic              q_push;
	logic              q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tmte_pkg::RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	// Front end: takes a word whenever the queue has room.
	tmte_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (q_push),
		.push_cmd (push_cmd)
	);

	tmte_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head     (head_cmd),
		.stat     (q_stat)
	);

	// Back end: cursor, screen memory and the result register.
	tmte_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (text_color_q),
		.cmd        (head_cmd),
		.q_stat     (q_stat),
		.pop        (q_pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {3'b000, res};

	// The back end must never take a command that is not there, and the
	// front end must never overrun the queue.
	`ASSERT_NEVER(a_pop_when_empty, q_pop && q_stat.empty, "pop from empty command queue")
	`ASSERT_NEVER(a_push_when_full, q_push && q_stat.full, "push into full command queue")
	// A reported cursor column always lies on the screen.
	`ASSERT_CLK(a_column_on_screen, m_tvalid |-> (int'(m_tdata[27:21]) < COLUMNS), "cursor column off screen")

endmodule

// ===== sv/tmte_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tmte_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/tmte_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short queue of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
module tmte_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tmte_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output tmte_pkg::cmd_t    head,
	output tmte_pkg::q_stat_t stat
);

	tmte_pkg::cmd_t         entry_q [tmte_pkg::QUEUE_DEPTH];
	logic [tmte_pkg::QPW-1:0] wr_ptr_q;
	logic [tmte_pkg::QPW-1:0] rd_ptr_q;
	logic [tmte_pkg::QPW:0]   count_q;

	always_comb begin
		stat.full  = (count_q == (tmte_pkg::QPW + 1)'(tmte_pkg::QUEUE_DEPTH));
		stat.empty = (count_q == '0);
		head       = entry_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== sv/tmte_front.sv =====
// ----------------------------------------------------------------------------
// Terminal front end
// Accepts input words and sorts them into command kinds for the queue.
// ----------------------------------------------------------------------------
module tmte_front (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,
	input  logic [1:0]        s_tuser,
	input  tmte_pkg::q_stat_t q_stat,
	output logic              push,
	output tmte_pkg::cmd_t    push_cmd
);

	logic [7:0] character;

	assign character = s_tdata[7:0];
	assign s_tready  = !q_stat.full;
	assign push      = s_tvalid && !q_stat.full;

	always_comb begin
		push_cmd.character  = character;
		push_cmd.cell_index = s_tdata[18:8];
		unique case (tmte_pkg::op_t'(s_tuser))
			tmte_pkg::OP_PUT: begin
				unique case (character)
					tmte_pkg::CHAR_BS:  push_cmd.kind = tmte_pkg::CMD_BS;
					tmte_pkg::CHAR_TAB: push_cmd.kind = tmte_pkg::CMD_TAB;
					tmte_pkg::CHAR_LF:  push_cmd.kind = tmte_pkg::CMD_LF;
					tmte_pkg::CHAR_CR:  push_cmd.kind = tmte_pkg::CMD_CR;
					default:            push_cmd.kind = tmte_pkg::CMD_PRINT;
				endcase
			end
			tmte_pkg::OP_READ:  push_cmd.kind = tmte_pkg::CMD_READ;
			tmte_pkg::OP_CLEAR: push_cmd.kind = tmte_pkg::CMD_CLEAR;
			default:            push_cmd.kind = tmte_pkg::CMD_NOP;
		endcase
	end

endmodule

// ===== sv/tmte_back.sv =====
// ----------------------------------------------------------------------------
// Terminal back end
// Owns the cursor and the screen memory, carries out commands, holds results.
// ----------------------------------------------------------------------------
module tmte_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        text_color,
	input  tmte_pkg::cmd_t    cmd,
	input  tmte_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              res_valid,
	input  logic              res_ready,
	output tmte_pkg::res_t    res
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int LAST_CELL_I = CELLS - 1;
	localparam int LAST_COL_I  = COLUMNS - 1;
	localparam int LAST_ROW_I  = ROWS - 1;
	localparam int TOP_LAST_I  = CELLS - COLUMNS;
	localparam logic [AW:0]   CELLS_X   = CELLS[AW:0];
	localparam logic [AW-1:0] LAST_CELL = LAST_CELL_I[AW-1:0];
	localparam logic [AW-1:0] LAST_COLA = LAST_COL_I[AW-1:0];
	localparam logic [AW-1:0] COLS_A    = COLUMNS[AW-1:0];
	localparam logic [AW-1:0] TOP_LAST  = TOP_LAST_I[AW-1:0];
	localparam logic [CW:0]   COLS_X    = COLUMNS[CW:0];
	localparam logic [RW:0]   ROWS_X    = ROWS[RW:0];
	localparam logic [RW-1:0] LAST_ROW  = LAST_ROW_I[RW-1:0];

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= CELLS_X) begin
			s = s - CELLS_X;
		end
		return s[AW-1:0];
	endfunction

	tmte_pkg::back_state_t state_q, state_d;
	tmte_pkg::cmd_t        cmd_q;
	logic [RW-1:0]  row_q, row_d;
	logic [CW-1:0]  col_q, col_d;
	logic [AW-1:0]  base_q, base_d;
	logic [AW-1:0]  cnt_q, cnt_d;
	logic [AW-1:0]  lin_q, lin_d;
	logic           scr_q, scr_d;
	logic           oor_q, oor_d;
	logic [15:0]    val_q, val_d;
	logic           ovalid_q, ovalid_d;
	tmte_pkg::res_t res_q, res_d;

	logic [CW:0]      col_e;
	logic [RW:0]      row_e;
	logic             scroll_e;
	logic [AW+10:0]   idx_x;
	logic [RW+4:0]    row_x;
	logic [CW+6:0]    col_x;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [15:0]      ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [15:0]      ram_rdata;

	tmte_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Logical read index mapped through the scroll base.
	assign idx_x     = (AW + 11)'(cmd_q.cell_index);
	assign ram_raddr = wrap_add(idx_x[AW-1:0], base_q);

	assign row_x = (RW + 5)'(row_q);
	assign col_x = (CW + 7)'(col_q);

	// Cursor movement for the put commands.
	always_comb begin
		col_e = {1'b0, col_q};
		row_e = {1'b0, row_q};
		case (cmd_q.kind)
			tmte_pkg::CMD_PRINT: col_e = {1'b0, col_q} + 1'b1;
			tmte_pkg::CMD_BS:    col_e = (col_q == '0) ? '0 : {1'b0, col_q} - 1'b1;
			tmte_pkg::CMD_TAB:   col_e = ({1'b0, col_q} | (CW + 1)'(7)) + 1'b1;
			tmte_pkg::CMD_LF: begin
				col_e = '0;
				row_e = {1'b0, row_q} + 1'b1;
			end
			tmte_pkg::CMD_CR:    col_e = '0;
			default:             col_e = {1'b0, col_q};
		endcase
		if (col_e >= COLS_X) begin
			col_e = '0;
			row_e = row_e + 1'b1;
		end
		scroll_e = (row_e >= ROWS_X);
		if (scroll_e) begin
			row_e = {1'b0, LAST_ROW};
		end
	end

	always_comb begin
		state_d   = state_q;
		row_d     = row_q;
		col_d     = col_q;
		base_d    = base_q;
		cnt_d     = cnt_q;
		lin_d     = lin_q;
		scr_d     = scr_q;
		oor_d     = oor_q;
		val_d     = val_q;
		ovalid_d  = ovalid_q && !res_ready;
		res_d     = res_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = {text_color, tmte_pkg::CHAR_SPACE};
		unique case (state_q)
			tmte_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = {tmte_pkg::RESET_ATTR, tmte_pkg::CHAR_SPACE};
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == LAST_CELL) begin
					state_d = tmte_pkg::ST_IDLE;
				end
			end
			tmte_pkg::ST_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = tmte_pkg::ST_EXEC;
				end
			end
			tmte_pkg::ST_EXEC: begin
				val_d = '0;
				scr_d = 1'b0;
				cnt_d = '0;
				case (cmd_q.kind)
					tmte_pkg::CMD_PRINT: begin
						lin_d   = AW'(row_q * COLUMNS) + AW'(col_q);
						row_d   = row_e[RW-1:0];
						col_d   = col_e[CW-1:0];
						scr_d   = scroll_e;
						state_d = tmte_pkg::ST_WRITE;
					end
					tmte_pkg::CMD_READ: begin
						oor_d   = !(int'(cmd_q.cell_index) < CELLS);
						state_d = tmte_pkg::ST_RDWAIT;
					end
					tmte_pkg::CMD_CLEAR: begin
						row_d   = '0;
						col_d   = '0;
						base_d  = '0;
						state_d = tmte_pkg::ST_FILL;
					end
					tmte_pkg::CMD_NOP: begin
						state_d = tmte_pkg::ST_RESP;
					end
					default: begin
						row_d   = row_e[RW-1:0];
						col_d   = col_e[CW-1:0];
						scr_d   = scroll_e;
						state_d = scroll_e ? tmte_pkg::ST_BLANK : tmte_pkg::ST_RESP;
					end
				endcase
			end
			tmte_pkg::ST_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = wrap_add(lin_q, base_q);
				ram_wdata = {text_color, cmd_q.character};
				state_d   = scr_q ? tmte_pkg::ST_BLANK : tmte_pkg::ST_RESP;
			end
			tmte_pkg::ST_BLANK: begin
				// The old top row becomes the new bottom row.
				ram_we    = 1'b1;
				ram_waddr = base_q + cnt_q;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == LAST_COLA) begin
					base_d  = (base_q == TOP_LAST) ? '0 : base_q + COLS_A;
					state_d = tmte_pkg::ST_RESP;
				end
			end
			tmte_pkg::ST_RDWAIT: begin
				val_d   = oor_q ? '0 : ram_rdata;
				state_d = tmte_pkg::ST_RESP;
			end
			tmte_pkg::ST_FILL: begin
				ram_we = 1'b1;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == LAST_CELL) begin
					state_d = tmte_pkg::ST_RESP;
				end
			end
			tmte_pkg::ST_RESP: begin
				if (!ovalid_q || res_ready) begin
					ovalid_d            = 1'b1;
					res_d.cell_value    = val_q;
					res_d.cursor_row    = row_x[4:0];
					res_d.cursor_column = col_x[6:0];
					res_d.scrolled      = scr_q;
					state_d             = tmte_pkg::ST_IDLE;
				end
			end
			default: state_d = tmte_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tmte_pkg::ST_INIT;
			row_q    <= '0;
			col_q    <= '0;
			base_q   <= '0;
			cnt_q    <= '0;
			scr_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			row_q    <= row_d;
			col_q    <= col_d;
			base_q   <= base_d;
			cnt_q    <= cnt_d;
			scr_q    <= scr_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
		lin_q <= lin_d;
		oor_q <= oor_d;
		val_q <= val_d;
		res_q <= res_d;
	end

	assign res_valid = ovalid_q;
	assign res       = res_q;

endmodule

// ===== tb/text_mode_terminal_engine_test.sv =====
// ----------------------------------------------------------------------------
// Text-mode terminal engine testbench
// Drives put, read, clear and spare operations into the engine and checks
// every result word against a cycle-free model of the screen and cursor. A
// short directed part covers the reset screen, out-of-range reads, the
// control codes and a tab that wraps at the right edge. Random traffic
// follows under several text colors and three stall patterns.
// ----------------------------------------------------------------------------
module text_mode_terminal_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	// The fourth operation code has no meaning; the engine only reports the cursor.
	localparam logic [1:0] OP_SPARE = 2'd3;

	// Every word produces a result, so the settle time after the last one only
	// has to cover a scrolling word's row blank plus some margin.
	localparam int SETTLE_CYCLES = 120;
	// The limit leaves a wide margin over the slowest correct run, including
	// the initial screen fill and the clears.
	localparam int CYCLE_LIMIT   = 600000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	// character [7:0], cell_index [18:8], zero [23:19]
	logic [23:0] s_tdata   = '0;
	// operation [1:0]
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// cell_value [15:0], cursor_row [20:16], cursor_column [27:21],
	// scrolled [28], zero [31:29]
	logic [31:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	// Model of the screen, the cursor and the color register.
	logic [15:0] screen_model [CELLS];
	int          cur_row;
	int          cur_col;
	logic [7:0]  attr;

	// Cursor and cell results still owed by the engine, oldest first.
	tmte_pkg::res_t pending_results [$];
	tmte_pkg::res_t got_word;
	tmte_pkg::res_t want_word;

	int          send_gap_pct   = 6;
	int          recv_stall_pct = 61;
	int          mismatches     = 0;
	int          word_count     = 0;
	int          read_count     = 0;
	int          scroll_count   = 0;
	int          cycle_count    = 0;

	text_mode_terminal_engine #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// Global watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[text_mode_terminal_engine] ERROR");
			$finish;
		end
	end

	// The receiver stalls at random with the percentage of the current phase.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Compute the result of one accepted word and update the model state. The
	// cursor is held in plain integers so that a tab may overshoot the last
	// column before the wrap pulls it back.
	task automatic predict_word(input logic [1:0] op, input logic [7:0] ch,
			input logic [10:0] idx, output tmte_pkg::res_t r);
		int pos;
		r = '0;
		case (op)
			tmte_pkg::OP_PUT: begin
				case (ch)
					tmte_pkg::CHAR_BS: begin
						if (cur_col > 0)
							cur_col--;
					end
					tmte_pkg::CHAR_TAB: cur_col = (cur_col / 8 + 1) * 8;
					tmte_pkg::CHAR_LF: begin
						cur_col = 0;
						cur_row++;
					end
					tmte_pkg::CHAR_CR: cur_col = 0;
					default: begin
						pos = cur_row * COLUMNS + cur_col;
						if (pos < CELLS)
							screen_model[pos] = {attr, ch};
						cur_col++;
					end
				endcase
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				// Passing the last row moves every row up by one and blanks the
				// bottom row in the current color.
				if (cur_row >= ROWS) begin
					for (int i = 0; i < CELLS - COLUMNS; i++)
						screen_model[i] = screen_model[i + COLUMNS];
					for (int i = CELLS - COLUMNS; i < CELLS; i++)
						screen_model[i] = {attr, tmte_pkg::CHAR_SPACE};
					cur_row = ROWS - 1;
					r.scrolled = 1'b1;
				end
			end
			tmte_pkg::OP_READ: begin
				// Indexes past the end of the screen read as zero.
				if (idx < CELLS)
					r.cell_value = screen_model[idx];
			end
			tmte_pkg::OP_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_model[i] = {attr, tmte_pkg::CHAR_SPACE};
				cur_row = 0;
				cur_col = 0;
			end
			default: ;
		endcase
		r.cursor_row    = cur_row[4:0];
		r.cursor_column = cur_col[6:0];
	endtask

	// Offer one word on the input stream. Called at a falling edge and returns
	// at one. Valid stays high into the next word unless a gap is drawn, so it
	// is never lowered and raised in the same step.
	task automatic send_word(input logic [1:0] op, input logic [7:0] ch,
			input logic [10:0] idx);
		tmte_pkg::res_t r;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {5'd0, idx, ch};
		do
			@(posedge clk);
		while (!s_tready);
		predict_word(op, ch, idx, r);
		pending_results.push_back(r);
		word_count++;
		if (op == tmte_pkg::OP_READ)
			read_count++;
		@(negedge clk);
	endtask

	// Lower valid and wait until every owed result has come back, then let the
	// engine settle so that a following register write finds it idle.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the text color register; only called while the engine is idle.
	task automatic set_color(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		attr = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Every accepted result word is compared with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_word = tmte_pkg::res_t'(m_tdata[28:0]);
			if (got_word.scrolled)
				scroll_count++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: cell %h row %0d col %0d scrolled %b",
						got_word.cell_value, got_word.cursor_row,
						got_word.cursor_column, got_word.scrolled);
			end else begin
				want_word = pending_results.pop_front();
				if (got_word.cell_value !== want_word.cell_value ||
						got_word.cursor_row !== want_word.cursor_row ||
						got_word.cursor_column !== want_word.cursor_column ||
						got_word.scrolled !== want_word.scrolled) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch at cycle %0d: expected cell %h row %0d col %0d ",
							"scrolled %b, got cell %h row %0d col %0d scrolled %b"},
							cycle_count, want_word.cell_value, want_word.cursor_row,
							want_word.cursor_column, want_word.scrolled,
							got_word.cell_value, got_word.cursor_row,
							got_word.cursor_column, got_word.scrolled);
				end
			end
		end
	end

	// The reset screen holds spaces in attribute 0x07; reads past the end give
	// zero, and the spare operation only reports the cursor.
	task automatic test_reset_contents();
		send_word(tmte_pkg::OP_READ, 8'h00, 11'd0);
		send_word(tmte_pkg::OP_READ, 8'hff, 11'd1999);
		send_word(tmte_pkg::OP_READ, 8'h00, 11'd2000);
		send_word(tmte_pkg::OP_READ, 8'h00, 11'h7ff);
		send_word(OP_SPARE, 8'h41, 11'h7ff);
	endtask

	// Printing, backspace stopping at column 0, carriage return, line feed, and
	// a run of tabs that lands on aligned columns and finally wraps the line.
	task automatic test_cursor_controls();
		send_word(tmte_pkg::OP_PUT, 8'h41, 11'd0);
		send_word(tmte_pkg::OP_PUT, 8'h00, 11'h7ff);
		send_word(tmte_pkg::OP_PUT, 8'hff, 11'd0);
		send_word(tmte_pkg::OP_READ, 8'h00, 11'd2);
		send_word(tmte_pkg::OP_PUT, tmte_pkg::CHAR_CR, 11'd0);
		send_word(tmte_pkg::OP_PUT, 8'h41, 11'd0);
		send_word(tmte_pkg::OP_PUT, tmte_pkg::CHAR_BS, 11'd0);
		send_word(tmte_pkg::OP_PUT, tmte_pkg::CHAR_BS, 11'd0);
		send_word(tmte_pkg::OP_PUT, tmte_pkg::CHAR_LF, 11'd0);
		repeat (10) send_word(tmte_pkg::OP_PUT, tmte_pkg::CHAR_TAB, 11'd0);
	endtask

	// Clearing fills the screen in the current color and homes the cursor.
	task automatic test_clear();
		send_word(tmte_pkg::OP_CLEAR, 8'h00, 11'd0);
		send_word(tmte_pkg::OP_READ, 8'h00, 11'd0);
		send_word(tmte_pkg::OP_READ, 8'h00, 11'd1999);
	endtask

	// Mostly lines of text broken by line feeds, so that the screen fills and
	// scrolls, mixed with control codes, reads, rare clears and spare codes.
	task automatic test_random(input int gap_pct, input int stall_pct, input int count);
		int         pick;
		logic [1:0] op;
		logic [7:0] ch;
		logic [10:0] idx;
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			pick = $urandom_range(999);
			op   = tmte_pkg::OP_PUT;
			ch   = 8'($urandom_range(255));
			idx  = 11'($urandom_range(2047));
			if (pick < 500)
				ch = 8'($urandom_range(8'h7e, 8'h20));
			else if (pick < 620)
				ch = tmte_pkg::CHAR_LF;
			else if (pick < 660)
				ch = tmte_pkg::CHAR_CR;
			else if (pick < 710)
				ch = tmte_pkg::CHAR_BS;
			else if (pick < 770)
				ch = tmte_pkg::CHAR_TAB;
			else if (pick < 795)
				op = tmte_pkg::OP_PUT;
			else if (pick < 975) begin
				op   = tmte_pkg::OP_READ;
				pick = $urandom_range(9);
				// Reads lean toward the cursor row, where the fresh text is.
				if (pick == 0)
					idx = 11'($urandom_range(2047, CELLS));
				else if (pick < 5)
					idx = 11'(cur_row * COLUMNS + int'($urandom_range(COLUMNS - 1)));
				else
					idx = 11'($urandom_range(CELLS - 1));
			end else if (pick < 995)
				op = OP_SPARE;
			else
				op = tmte_pkg::OP_CLEAR;
			send_word(op, ch, idx);
		end
		wait_drain();
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++)
			screen_model[i] = {tmte_pkg::RESET_ATTR, tmte_pkg::CHAR_SPACE};
		cur_row = 0;
		cur_col = 0;
		attr    = tmte_pkg::RESET_ATTR;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the first stall pattern; the reset color holds until the clear test, which runs in color 0x00.
		test_reset_contents();
		test_cursor_controls();
		wait_drain();
		set_color(8'h00);
		test_clear();
		wait_drain();

		// Random part: sender rarely idle, receiver often stalled; then the
		// other way round; then full rate on both sides.
		set_color(8'hff);
		test_random(6, 61, 270);
		set_color(8'($urandom_range(255)));
		test_random(61, 6, 270);
		set_color(8'($urandom_range(255)));
		test_random(0, 0, 260);

		$display("Sent %0d words (%0d reads), saw %0d scrolls, %0d mismatches.",
			word_count, read_count, scroll_count, mismatches);
		$display("Covered reset contents, control codes, clears and four color settings.");
		if (mismatches == 0) begin
			$display("[text_mode_terminal_engine] OK");
		end else begin
			$display("[text_mode_terminal_engine] ERROR");
		end
		$finish;
	end

endmodule
